// ===== sv/nlc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nlc_pkg
// Types and character constants for the number literal classifier.
// ----------------------------------------------------------------------------
package nlc_pkg;

    typedef enum logic [3:0] {
        PH_START    = 4'd0,
        PH_SIGN     = 4'd1,
        PH_ZERO     = 4'd2,
        PH_NEGZERO  = 4'd3,
        PH_INT      = 4'd4,
        PH_DOT      = 4'd5,
        PH_FRAC     = 4'd6,
        PH_EXP_E    = 4'd7,
        PH_EXP_SIGN = 4'd8,
        PH_EXP_DIG  = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_INT   = 2'd1,
        CLS_FLOAT = 2'd2
    } t_class;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int unsigned REG_ADDR_W = 3;
    localparam logic        REG_STRICT = 1'b0;

endpackage
`default_nettype wire

// ===== sv/number_literal_classifier.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// number_literal_classifier
// Classifies a character stream token as not a number, integer or float.
// ----------------------------------------------------------------------------
// Characters enter one per word, with tlast on the final character of a
// token. Each word is held in an input register, where the grammar
// state machine consumes it; the class of a token is registered in the
// output register when its last character advances. One word is taken
// every cycle; the only stall comes from a class word that waits in the
// output register while the next last character is ready to complete.
// Register 0 at address 0 is strict_mode (reset 1); write it only while
// no token is in flight.
module number_literal_classifier (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,   // last_char
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [1:0] number_class, [7:2] zero
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [nlc_pkg::REG_ADDR_W-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic              r_strict;
    logic              r_in_valid;
    logic [7:0]        r_char;
    logic              r_last;
    nlc_pkg::t_phase   r_phase;
    logic              r_mant;
    logic              r_frac;
    logic              r_exp;
    logic              r_rej;
    logic              r_out_valid;
    nlc_pkg::t_class   r_class;

    nlc_pkg::t_phase   n_phase;
    logic              n_mant;
    logic              n_frac;
    logic              n_exp;
    logic              n_rej;
    nlc_pkg::t_class   n_class;
    nlc_pkg::t_phase   nx;
    logic              nx_bad;
    logic              advance;
    logic              is_dig;
    logic              is_e;
    logic              is_sgn;

    assign pready = 1'b1;
    assign prdata = (paddr[nlc_pkg::REG_ADDR_W-1] == nlc_pkg::REG_STRICT) ?
                    {31'd0, r_strict} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b1;
        end else if (psel && penable && pwrite &&
                     paddr[nlc_pkg::REG_ADDR_W-1] == nlc_pkg::REG_STRICT) begin
            r_strict <= pwdata[0];
        end
    end

    assign advance = r_in_valid && (!r_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    assign is_dig = (r_char >= nlc_pkg::CH_ZERO) && (r_char <= nlc_pkg::CH_NINE);
    assign is_e   = (r_char == nlc_pkg::CH_LO_E) || (r_char == nlc_pkg::CH_UP_E);
    assign is_sgn = (r_char == nlc_pkg::CH_PLUS) || (r_char == nlc_pkg::CH_MINUS);

    always_comb begin
        nx     = r_phase;
        nx_bad = 1'b0;
        if (r_strict) begin
            unique case (r_phase)
                nlc_pkg::PH_START: begin
                    if (r_char == nlc_pkg::CH_MINUS) nx = nlc_pkg::PH_SIGN;
                    else if (r_char == nlc_pkg::CH_ZERO) nx = nlc_pkg::PH_ZERO;
                    else if (is_dig) nx = nlc_pkg::PH_INT;
                    else nx_bad = 1'b1;
                end
                nlc_pkg::PH_SIGN: begin
                    if (r_char == nlc_pkg::CH_ZERO) nx = nlc_pkg::PH_NEGZERO;
                    else if (is_dig) nx = nlc_pkg::PH_INT;
                    else nx_bad = 1'b1;
                end
                nlc_pkg::PH_ZERO, nlc_pkg::PH_NEGZERO, nlc_pkg::PH_INT: begin
                    if (is_dig) begin
                        if (r_phase == nlc_pkg::PH_INT) nx = nlc_pkg::PH_INT;
                        else nx_bad = 1'b1;
                    end else if (r_char == nlc_pkg::CH_DOT) nx = nlc_pkg::PH_DOT;
                    else if (is_e) nx = nlc_pkg::PH_EXP_E;
                    else nx_bad = 1'b1;
                end
                nlc_pkg::PH_DOT: begin
                    if (is_dig) nx = nlc_pkg::PH_FRAC;
                    else nx_bad = 1'b1;
                end
                nlc_pkg::PH_FRAC: begin
                    if (is_dig) nx = nlc_pkg::PH_FRAC;
                    else if (is_e) nx = nlc_pkg::PH_EXP_E;
                    else nx_bad = 1'b1;
                end
                nlc_pkg::PH_EXP_E: begin
                    if (is_sgn) nx = nlc_pkg::PH_EXP_SIGN;
                    else if (is_dig) nx = nlc_pkg::PH_EXP_DIG;
                    else nx_bad = 1'b1;
                end
                nlc_pkg::PH_EXP_SIGN, nlc_pkg::PH_EXP_DIG: begin
                    if (is_dig) nx = nlc_pkg::PH_EXP_DIG;
                    else nx_bad = 1'b1;
                end
                default: nx_bad = 1'b1;
            endcase
        end else begin
            unique case (r_phase)
                nlc_pkg::PH_START, nlc_pkg::PH_SIGN: begin
                    if (r_phase == nlc_pkg::PH_START && is_sgn) nx = nlc_pkg::PH_SIGN;
                    else if (is_dig) nx = nlc_pkg::PH_INT;
                    else if (r_char == nlc_pkg::CH_DOT) nx = nlc_pkg::PH_DOT;
                    else nx_bad = 1'b1;
                end
                nlc_pkg::PH_ZERO, nlc_pkg::PH_NEGZERO, nlc_pkg::PH_INT: begin
                    if (is_dig) nx = nlc_pkg::PH_INT;
                    else if (r_char == nlc_pkg::CH_DOT) nx = nlc_pkg::PH_DOT;
                    else if (is_e && r_mant) nx = nlc_pkg::PH_EXP_E;
                    else nx_bad = 1'b1;
                end
                nlc_pkg::PH_DOT, nlc_pkg::PH_FRAC: begin
                    if (is_dig) nx = nlc_pkg::PH_FRAC;
                    else if (is_e && r_mant) nx = nlc_pkg::PH_EXP_E;
                    else nx_bad = 1'b1;
                end
                nlc_pkg::PH_EXP_E: begin
                    if (is_sgn) nx = nlc_pkg::PH_EXP_SIGN;
                    else if (is_dig) nx = nlc_pkg::PH_EXP_DIG;
                    else nx_bad = 1'b1;
                end
                nlc_pkg::PH_EXP_SIGN, nlc_pkg::PH_EXP_DIG: begin
                    if (is_dig) nx = nlc_pkg::PH_EXP_DIG;
                    else nx_bad = 1'b1;
                end
                default: nx_bad = 1'b1;
            endcase
        end
        if (r_char == nlc_pkg::CH_NUL) nx_bad = 1'b1;
    end

    always_comb begin
        n_phase = r_phase;
        n_mant  = r_mant;
        n_frac  = r_frac;
        n_exp   = r_exp;
        n_rej   = r_rej;
        if (!r_rej) begin
            if (nx_bad) begin
                n_rej = 1'b1;
            end else begin
                n_phase = nx;
                if (nx == nlc_pkg::PH_DOT) n_frac = 1'b1;
                if (nx == nlc_pkg::PH_EXP_E) n_exp = 1'b1;
                if (is_dig && nx <= nlc_pkg::PH_FRAC) n_mant = 1'b1;
            end
        end

        n_class = nlc_pkg::CLS_NONE;
        if (!n_rej) begin
            if (r_strict) begin
                if (n_phase == nlc_pkg::PH_ZERO || n_phase == nlc_pkg::PH_INT) begin
                    n_class = nlc_pkg::CLS_INT;
                end else if (n_phase == nlc_pkg::PH_FRAC ||
                             n_phase == nlc_pkg::PH_EXP_DIG) begin
                    n_class = nlc_pkg::CLS_FLOAT;
                end
            end else if (n_mant && (n_phase == nlc_pkg::PH_ZERO ||
                         n_phase == nlc_pkg::PH_NEGZERO || n_phase == nlc_pkg::PH_INT ||
                         n_phase == nlc_pkg::PH_DOT || n_phase == nlc_pkg::PH_FRAC ||
                         n_phase == nlc_pkg::PH_EXP_DIG)) begin
                n_class = (n_frac || n_exp) ? nlc_pkg::CLS_FLOAT : nlc_pkg::CLS_INT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= nlc_pkg::PH_START;
            r_mant      <= 1'b0;
            r_frac      <= 1'b0;
            r_exp       <= 1'b0;
            r_rej       <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance && r_last) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                if (r_last) begin
                    r_phase <= nlc_pkg::PH_START;
                    r_mant  <= 1'b0;
                    r_frac  <= 1'b0;
                    r_exp   <= 1'b0;
                    r_rej   <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_mant  <= n_mant;
                    r_frac  <= n_frac;
                    r_exp   <= n_exp;
                    r_rej   <= n_rej;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_char <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
        if (advance && r_last) begin
            r_class <= n_class;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_class};

endmodule
`default_nettype wire
